// ===== rtl/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and codes for the transposition table engine.
// ----------------------------------------------------------------------------
package tte_pkg;

	localparam logic [1:0] OP_PROBE = 2'd0;
	localparam logic [1:0] OP_RECORD = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_AGE = 2'd3;

	localparam logic [2:0] ST_MISS = 3'd0;
	localparam logic [2:0] ST_HIT = 3'd1;
	localparam logic [2:0] ST_HINT = 3'd2;
	localparam logic [2:0] ST_RECORDED = 3'd3;
	localparam logic [2:0] ST_SKIPPED = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	localparam logic [1:0] FLAG_NONE = 2'd0;
	localparam logic [1:0] FLAG_UPPER = 2'd1;
	localparam logic [1:0] FLAG_LOWER = 2'd2;
	localparam logic [1:0] FLAG_EXACT = 2'd3;

	localparam logic [14:0] MATE_RESET = 15'd28000;
	localparam logic [14:0] WIN_RESET = 15'd32000;
	localparam logic signed [8:0] AGE_STEP = 9'sd2;

	typedef struct packed {
		logic [1:0]         flag;
		logic signed [7:0]  depth;
		logic signed [15:0] value;
		logic [15:0]        mv;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input beat
		logic rd;        // read entry at working address
		logic op_wr;     // write back record outcome
		logic sweep_rd;  // read sweep address
		logic sweep_wr;  // write aged/cleared entry
		logic cnt_clr;   // restart sweep counter
		logic res_load;  // present result
		logic init_wr;   // zero one entry after reset
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       sweep_last;
		logic       cnt_last;
		logic [1:0] op;
	} dp_sts_t;

endpackage

// ===== rtl/tte_ctrl.sv =====
// ----------------------------------------------------------------------------
// tte_ctrl
// Sequencer for lookup, write-back and table sweeps.
// ----------------------------------------------------------------------------
module tte_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              res_busy,
	input  tte_pkg::dp_sts_t  sts,
	output logic              in_ready,
	output tte_pkg::dp_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_INIT  = 6'b000001,
		S_IDLE  = 6'b000010,
		S_READ  = 6'b000100,
		S_EVAL  = 6'b001000,
		S_SWEEP = 6'b010000,
		S_SWWR  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_INIT: begin
				// zero both tables once after reset
				cmd.init_wr = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = !res_busy;
				if (in_fire) begin
					cmd.load = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (sts.op == tte_pkg::OP_PROBE || sts.op == tte_pkg::OP_RECORD) begin
					cmd.rd = 1'b1;
					state_d = S_EVAL;
				end else begin
					cmd.sweep_rd = 1'b1;
					state_d = S_SWWR;
				end
			end
			S_EVAL: begin
				cmd.op_wr = 1'b1;
				cmd.res_load = 1'b1;
				state_d = S_IDLE;
			end
			S_SWEEP: begin
				cmd.sweep_rd = 1'b1;
				state_d = S_SWWR;
			end
			S_SWWR: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SWEEP;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE) else $error("load outside idle");
	a_read_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> state_q == S_EVAL) else $error("read not followed by eval");

endmodule

// ===== rtl/tte_dp.sv =====
// ----------------------------------------------------------------------------
// tte_dp
// Table storage, probe/record evaluation and sweep logic.
// ----------------------------------------------------------------------------
module tte_dp #(
	parameter int INDEX_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tte_pkg::dp_cmd_t     cmd,
	output tte_pkg::dp_sts_t     sts,
	input  logic [14:0]          mate_thr,
	input  logic [14:0]          win_thr,
	input  logic [1:0]           operation,
	input  logic                 side,
	input  logic [31:0]          zobrist_key,
	input  logic [63:0]          zobrist_lock,
	input  logic signed [15:0]   alpha_bound,
	input  logic signed [15:0]   beta_bound,
	input  logic signed [7:0]    search_depth,
	input  logic [7:0]           ply,
	input  logic signed [15:0]   score,
	input  logic [1:0]           bound_kind,
	input  logic [15:0]          move,
	input  logic                 res_take,
	output logic                 res_valid,
	output logic [2:0]           res_status,
	output logic signed [15:0]   res_value,
	output logic [15:0]          res_hint
);

	localparam int AW = INDEX_BITS + 1;
	localparam int DEPTH = 2 ** AW;

	logic [63:0]           lock_mem [DEPTH];
	tte_pkg::entry_t       ent_mem [DEPTH];

	logic [1:0]            op_q;
	logic [AW-1:0]         addr_q;
	logic [63:0]           lock_q;
	logic signed [15:0]    alpha_q, beta_q, score_q;
	logic signed [7:0]     depth_q;
	logic [7:0]            ply_q;
	logic [1:0]            kind_q;
	logic [15:0]           mv_q;
	logic [AW-1:0]         cnt_q;
	logic [AW-1:0]         sw_addr_q;
	logic [63:0]           rd_lock_q;
	tte_pkg::entry_t       rd_ent_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			addr_q  <= {side, zobrist_key[INDEX_BITS-1:0]};
			lock_q  <= zobrist_lock;
			alpha_q <= alpha_bound;
			beta_q  <= beta_bound;
			score_q <= score;
			depth_q <= search_depth;
			ply_q   <= ply;
			kind_q  <= bound_kind;
			mv_q    <= move;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.sweep_rd || cmd.init_wr) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	assign sts.op = op_q;
	assign sts.sweep_last = (sw_addr_q == {AW{1'b1}});
	assign sts.cnt_last = (cnt_q == {AW{1'b1}});

	// shared evaluation terms
	logic signed [16:0] mate_p, mate_n;
	assign mate_p = {2'b00, mate_thr};
	assign mate_n = -mate_p;

	// probe
	logic signed [16:0] sv, pv;
	logic               p_mated, p_done, p_match;
	always_comb begin
		sv = 17'(rd_ent_q.value);
		p_mated = 1'b0;
		pv = sv;
		if (sv > mate_p) begin
			p_mated = 1'b1;
			pv = sv - 17'($signed({1'b0, ply_q}));
		end else if (sv < mate_n) begin
			p_mated = 1'b1;
			pv = sv + 17'($signed({1'b0, ply_q}));
		end
		p_match = (rd_lock_q == lock_q);
		p_done = 1'b0;
		if (rd_ent_q.flag != tte_pkg::FLAG_NONE && (rd_ent_q.depth >= depth_q || p_mated)) begin
			p_done = (rd_ent_q.flag == tte_pkg::FLAG_LOWER && pv >= 17'(beta_q)) ||
			         (rd_ent_q.flag == tte_pkg::FLAG_UPPER && pv <= 17'(alpha_q)) ||
			         (rd_ent_q.flag == tte_pkg::FLAG_EXACT);
		end
	end

	// record
	logic signed [16:0] rs, win_p;
	logic signed [15:0] rsat;
	logic               r_skip;
	always_comb begin
		win_p = {2'b00, win_thr};
		r_skip = (rd_ent_q.flag != tte_pkg::FLAG_NONE && rd_ent_q.depth > depth_q) ||
		         17'(score_q) < -win_p || 17'(score_q) > win_p;
		rs = 17'(score_q);
		if (rs > mate_p) begin
			rs = rs + 17'($signed({1'b0, ply_q}));
		end else if (rs < mate_n) begin
			rs = rs - 17'($signed({1'b0, ply_q}));
		end
		if (rs > 17'sd32767) begin
			rsat = 16'sh7fff;
		end else if (rs < -17'sd32768) begin
			rsat = 16'sh8000;
		end else begin
			rsat = rs[15:0];
		end
	end

	// sweep
	tte_pkg::entry_t    sw_ent;
	logic signed [8:0]  aged;
	always_comb begin
		sw_ent = rd_ent_q;
		aged = 9'(rd_ent_q.depth) - tte_pkg::AGE_STEP;
		if (op_q == tte_pkg::OP_CLEAR) begin
			sw_ent.flag = tte_pkg::FLAG_NONE;
		end else begin
			if (17'(rd_ent_q.value) > mate_p || 17'(rd_ent_q.value) < mate_n) begin
				sw_ent.flag = tte_pkg::FLAG_NONE;
			end
			sw_ent.depth = (aged < -9'sd128) ? -8'sd128 : aged[7:0];
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_lock_q <= lock_mem[addr_q];
			rd_ent_q  <= ent_mem[addr_q];
		end else if (cmd.sweep_rd) begin
			rd_ent_q  <= ent_mem[cnt_q];
			sw_addr_q <= cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op_wr && op_q == tte_pkg::OP_RECORD && !r_skip) begin
			lock_mem[addr_q] <= lock_q;
			ent_mem[addr_q]  <= '{flag: kind_q, depth: depth_q, value: rsat, mv: mv_q};
		end else if (cmd.sweep_wr) begin
			ent_mem[sw_addr_q] <= sw_ent;
		end else if (cmd.init_wr) begin
			lock_mem[cnt_q] <= '0;
			ent_mem[cnt_q]  <= '0;
		end
	end

	// result register
	logic [2:0]         res_status_d;
	logic signed [15:0] res_value_d;
	logic [15:0]        res_hint_d;

	always_comb begin
		res_status_d = tte_pkg::ST_CLEARED;
		res_value_d  = '0;
		res_hint_d   = '0;
		if (op_q == tte_pkg::OP_PROBE) begin
			res_status_d = tte_pkg::ST_MISS;
			if (p_match && p_done) begin
				res_status_d = tte_pkg::ST_HIT;
				res_value_d  = pv[15:0];
			end else if (p_match && rd_ent_q.mv != 16'd0 && rd_ent_q.depth > 8'sd0) begin
				res_status_d = tte_pkg::ST_HINT;
				res_hint_d   = rd_ent_q.mv;
			end
		end else if (op_q == tte_pkg::OP_RECORD) begin
			res_status_d = r_skip ? tte_pkg::ST_SKIPPED : tte_pkg::ST_RECORDED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.res_load) begin
			res_valid <= 1'b1;
		end else if (res_take) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status <= res_status_d;
			res_value  <= res_value_d;
			res_hint   <= res_hint_d;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_take |=> res_valid) else $error("result lost");
	a_excl_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.op_wr && cmd.sweep_wr)) else $error("two writes at once");
	a_sweep_op: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_wr |-> (op_q == tte_pkg::OP_CLEAR || op_q == tte_pkg::OP_AGE))
		else $error("sweep on lookup op");

endmodule

// ===== rtl/transposition_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// transposition_table_engine_core
// Two-sided direct-mapped transposition table with depth-preferred replace.
// ----------------------------------------------------------------------------
//  channel | dir | signals                   | content
//  s_axis  | in  | tvalid tready tdata       | one operation
//  m_axis  | out | tvalid tready tdata       | status, value, hint
//  apb     | in  | psel penable pwrite ...   | mate/win thresholds
//
// Probe and record go through a read, an evaluate and write back, and an accept step.
// Clears and ages do one read and one write per entry
// over the single table port, both sides.
// After reset a clearing pass zeroes every lock and entry, one per cycle,
// with s_axis tready held low. Stall on m_axis holds
// s_axis tready low until the pending result is taken.
module transposition_table_engine_core #(
	parameter int INDEX_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// operation[1:0] side[2] zobrist_key[34:3] zobrist_lock[98:35]
	// alpha_bound[114:99] beta_bound[130:115] search_depth[138:131]
	// ply[146:139] score[162:147] bound_kind[164:163] move[180:165]
	input  logic [183:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[2:0] value[18:3] hint_move[34:19]
	output logic [39:0]  m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam logic [2:0] ADDR_MATE = 3'd0;
	localparam logic [2:0] ADDR_WIN = 3'd4;

	logic [14:0] mate_q, win_q;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_q <= tte_pkg::MATE_RESET;
			win_q  <= tte_pkg::WIN_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_MATE) mate_q <= pwdata[14:0];
			if (paddr == ADDR_WIN)  win_q  <= pwdata[14:0];
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_MATE: prdata = {17'd0, mate_q};
			ADDR_WIN:  prdata = {17'd0, win_q};
			default:   prdata = '0;
		endcase
	end

	tte_pkg::dp_cmd_t cmd;
	tte_pkg::dp_sts_t sts;
	logic             in_fire;
	logic [2:0]       st;
	logic [15:0]      val, hint;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	tte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.res_busy (m_axis_tvalid && !m_axis_tready),
		.sts      (sts),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	tte_dp #(.INDEX_BITS(INDEX_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mate_thr     (mate_q),
		.win_thr      (win_q),
		.operation    (s_axis_tdata[1:0]),
		.side         (s_axis_tdata[2]),
		.zobrist_key  (s_axis_tdata[34:3]),
		.zobrist_lock (s_axis_tdata[98:35]),
		.alpha_bound  (s_axis_tdata[114:99]),
		.beta_bound   (s_axis_tdata[130:115]),
		.search_depth (s_axis_tdata[138:131]),
		.ply          (s_axis_tdata[146:139]),
		.score        (s_axis_tdata[162:147]),
		.bound_kind   (s_axis_tdata[164:163]),
		.move         (s_axis_tdata[180:165]),
		.res_take     (m_axis_tready),
		.res_valid    (m_axis_tvalid),
		.res_status   (st),
		.res_value    (val),
		.res_hint     (hint)
	);

	assign m_axis_tdata = {5'd0, hint, val, st};

endmodule

// ===== tb/transposition_table_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// transposition_table_engine_core_test
// Drives probe, record, clear and age operations into the engine over the
// input stream and checks every result beat against a local table model.
// Runs directed cases, threshold register changes, a long output hold-off
// and random traffic under several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module transposition_table_engine_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_BITS = 16;
	localparam int WATCHDOG_LIMIT = 1500000;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES = 400;
	localparam logic [2:0] ADDR_MATE = 3'd0;
	localparam logic [2:0] ADDR_WIN = 3'd4;

	typedef struct {
		logic [1:0]         op;
		logic               side;
		logic [31:0]        key;
		logic [63:0]        lock;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic signed [7:0]  depth;
		logic [7:0]         ply;
		logic signed [15:0] score;
		logic [1:0]         kind;
		logic [15:0]        mv;
	} tt_op_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] value;
		logic [15:0] hint;
	} tt_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [183:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [39:0]  m_axis_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	// table model: entries never written read as zero
	logic [63:0]      lock_tab[int];
	tte_pkg::entry_t  entry_tab[int];
	int               mate_lim;
	int               win_lim;

	tt_res_t     pending_res[$];
	int          errors = 0;
	int          gap_pct;
	int          stall_pct;
	logic        hold_tog = 1'b0;
	logic        hold_seen_q = 1'b0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	logic [15:0] idx_pool[16];
	logic [63:0] lock_pool[4];

	transposition_table_engine_core #(.INDEX_BITS(IDX_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic tt_res_t table_outcome(input tt_op_t it);
		tt_res_t         r;
		int              idx;
		tte_pkg::entry_t e;
		logic [63:0]     lk;
		int              v;
		int              s;
		logic            mated;
		logic            done;
		r = '0;
		idx = (int'(it.side) << IDX_BITS) | int'(it.key[IDX_BITS-1:0]);
		e = entry_tab.exists(idx) ? entry_tab[idx] : '0;
		lk = lock_tab.exists(idx) ? lock_tab[idx] : '0;
		case (it.op)
			tte_pkg::OP_PROBE: begin
				if (lk == it.lock) begin
					done = 1'b0;
					if (e.flag != tte_pkg::FLAG_NONE) begin
						v = int'(e.value);
						mated = 1'b0;
						if (v > mate_lim) begin
							mated = 1'b1;
							v -= int'(it.ply);
						end else if (v < -mate_lim) begin
							mated = 1'b1;
							v += int'(it.ply);
						end
						if (int'(e.depth) >= int'(it.depth) || mated) begin
							if ((e.flag == tte_pkg::FLAG_LOWER && v >= int'(it.beta)) ||
							    (e.flag == tte_pkg::FLAG_UPPER && v <= int'(it.alpha)) ||
							    e.flag == tte_pkg::FLAG_EXACT) begin
								r.status = tte_pkg::ST_HIT;
								r.value = v[15:0];
								done = 1'b1;
							end
						end
					end
					if (!done && e.mv != 16'd0 && e.depth > 8'sd0) begin
						r.status = tte_pkg::ST_HINT;
						r.hint = e.mv;
					end
				end else begin
					r.status = tte_pkg::ST_MISS;
				end
			end
			tte_pkg::OP_RECORD: begin
				s = int'(it.score);
				if ((e.flag != tte_pkg::FLAG_NONE && int'(e.depth) > int'(it.depth)) ||
				    s < -win_lim || s > win_lim) begin
					r.status = tte_pkg::ST_SKIPPED;
				end else begin
					if (s > mate_lim) s += int'(it.ply);
					else if (s < -mate_lim) s -= int'(it.ply);
					if (s > 32767) s = 32767;
					if (s < -32768) s = -32768;
					lock_tab[idx] = it.lock;
					entry_tab[idx] = '{flag: it.kind, depth: it.depth, value: s[15:0],
						mv: it.mv};
					r.status = tte_pkg::ST_RECORDED;
				end
			end
			tte_pkg::OP_CLEAR: begin
				foreach (entry_tab[i]) entry_tab[i].flag = tte_pkg::FLAG_NONE;
				r.status = tte_pkg::ST_CLEARED;
			end
			default: begin
				foreach (entry_tab[i]) begin
					v = int'(entry_tab[i].value);
					if (v > mate_lim || v < -mate_lim) entry_tab[i].flag = tte_pkg::FLAG_NONE;
					s = int'(entry_tab[i].depth) - 2;
					if (s < -128) s = -128;
					entry_tab[i].depth = s[7:0];
				end
				r.status = tte_pkg::ST_CLEARED;
			end
		endcase
		return r;
	endfunction

	task automatic send_op(input tt_op_t it);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b0, it.mv, it.kind, it.score, it.ply, it.depth, it.beta,
			it.alpha, it.lock, it.key, it.side, it.op};
		// tready is settled mid-cycle and holds until the next edge
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		pending_res.push_back(table_outcome(it));
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [14:0] val);
		s_axis_tvalid <= 1'b0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {17'b0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_MATE) mate_lim = int'(val);
		else win_lim = int'(val);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic tt_op_t make_op(input logic [1:0] op, input logic side,
		input logic [31:0] key, input logic [63:0] lock, input int depth,
		input int ply, input int score, input logic [1:0] kind, input logic [15:0] mv,
		input int alpha, input int beta);
		tt_op_t it;
		it.op = op;
		it.side = side;
		it.key = key;
		it.lock = lock;
		it.depth = depth[7:0];
		it.ply = ply[7:0];
		it.score = score[15:0];
		it.kind = kind;
		it.mv = mv;
		it.alpha = alpha[15:0];
		it.beta = beta[15:0];
		return it;
	endfunction

	function automatic int pick_score();
		int r;
		r = $urandom_range(99);
		if (r < 40) return $urandom_range(1000) - 500;
		if (r < 60) return mate_lim + $urandom_range(40) - 20;
		if (r < 70) return -mate_lim + $urandom_range(40) - 20;
		if (r < 80) return win_lim + $urandom_range(4) - 2;
		if (r < 85) return -win_lim + $urandom_range(4) - 2;
		return int'($signed(16'($urandom)));
	endfunction

	function automatic tt_op_t random_op();
		tt_op_t it;
		it.op = ($urandom_range(99) < 45) ? tte_pkg::OP_PROBE : tte_pkg::OP_RECORD;
		it.side = 1'($urandom_range(1));
		it.key = {16'($urandom), idx_pool[$urandom_range(15)]};
		it.lock = lock_pool[$urandom_range(3)];
		if ($urandom_range(99) < 8) begin
			it.key = $urandom;
			it.lock = {$urandom, $urandom};
		end
		it.depth = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15) - 3);
		it.ply = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20));
		it.score = 16'(pick_score());
		it.kind = 2'($urandom_range(3));
		it.mv = ($urandom_range(9) == 0) ? 16'h0 : 16'($urandom);
		it.alpha = 16'(pick_score());
		it.beta = 16'(pick_score());
		return it;
	endfunction

	task automatic test_basic_ops();
		logic [63:0] la;
		logic [63:0] lb;
		la = 64'hFFFF_FFFF_FFFF_FFFF;
		lb = 64'h8000_0000_0000_0001;
		// untouched entry with zero lock
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0001, 64'h0, 0, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, 0, 0));
		send_op(make_op(tte_pkg::OP_RECORD, 1'b0, 32'hFFFF_0010, la, 5, 0, 100,
			tte_pkg::FLAG_EXACT, 16'h1234, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0010, la, 3, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0010, lb, 3, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0010, la, 10, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, 0, 0));
		// shallower record onto a bounded entry
		send_op(make_op(tte_pkg::OP_RECORD, 1'b0, 32'h0000_0010, la, 1, 0, 7,
			tte_pkg::FLAG_LOWER, 16'h1, 0, 0));
		// no bound: hint only
		send_op(make_op(tte_pkg::OP_RECORD, 1'b1, 32'h0000_FFFF, lb, 3, 0, 0,
			tte_pkg::FLAG_NONE, 16'hFFFF, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b1, 32'h0000_FFFF, lb, -128, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, -32768, -32768));
		send_op(make_op(tte_pkg::OP_RECORD, 1'b1, 32'h0, la, 3, 0, 32767,
			tte_pkg::FLAG_EXACT, 16'h1, 0, 0));
		send_op(make_op(tte_pkg::OP_RECORD, 1'b1, 32'h0, la, 3, 0, -32768,
			tte_pkg::FLAG_EXACT, 16'h1, 0, 0));
		// mate score with ply offset, depth ignored on probe
		send_op(make_op(tte_pkg::OP_RECORD, 1'b0, 32'h0000_0020, la, 0, 200, 31000,
			tte_pkg::FLAG_LOWER, 16'h0042, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0020, la, 127, 200, 0,
			tte_pkg::FLAG_NONE, 16'h0, 0, 30000));
		send_op(make_op(tte_pkg::OP_RECORD, 1'b0, 32'h0000_0030, la, 4, 0, -50,
			tte_pkg::FLAG_UPPER, 16'h0777, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0030, la, 4, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, -40, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0030, la, 4, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, -60, 0));
		// zero move and nonpositive depth give no hint
		send_op(make_op(tte_pkg::OP_RECORD, 1'b0, 32'h0000_0040, la, 2, 0, 10,
			tte_pkg::FLAG_LOWER, 16'h0, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0040, la, 0, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, 0, 100));
		send_op(make_op(tte_pkg::OP_RECORD, 1'b0, 32'h0000_0050, la, 0, 0, 0,
			tte_pkg::FLAG_LOWER, 16'h0005, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0050, la, -1, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, 0, 32767));
		wait_drained();
	endtask

	task automatic test_clears();
		send_op(make_op(tte_pkg::OP_CLEAR, 1'b1, 32'hFFFF_FFFF, 64'h5, 1, 1, 1,
			tte_pkg::FLAG_EXACT, 16'h1, 1, 1));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0010, 64'hFFFF_FFFF_FFFF_FFFF,
			0, 0, 0, tte_pkg::FLAG_NONE, 16'h0, 0, 0));
		send_op(make_op(tte_pkg::OP_RECORD, 1'b0, 32'h0000_0020, 64'hFFFF_FFFF_FFFF_FFFF,
			6, 3, -29000, tte_pkg::FLAG_UPPER, 16'h00AA, 0, 0));
		send_op(make_op(tte_pkg::OP_RECORD, 1'b0, 32'h0000_0060, 64'h7, -127, 0, 5,
			tte_pkg::FLAG_EXACT, 16'h00BB, 0, 0));
		send_op(make_op(tte_pkg::OP_AGE, 1'b0, 32'h0, 64'h0, 0, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0020, 64'hFFFF_FFFF_FFFF_FFFF,
			0, 3, 0, tte_pkg::FLAG_NONE, 16'h0, 32767, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0060, 64'h7, -128, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b0, 32'h0000_0010, 64'hFFFF_FFFF_FFFF_FFFF,
			0, 0, 0, tte_pkg::FLAG_NONE, 16'h0, 0, 0));
		wait_drained();
	endtask

	task automatic test_thresholds();
		write_reg(ADDR_MATE, 15'd0);
		write_reg(ADDR_WIN, 15'h7FFF);
		// saturating mate adjustment
		send_op(make_op(tte_pkg::OP_RECORD, 1'b1, 32'h0000_0100, 64'h1, 9, 255, 32767,
			tte_pkg::FLAG_EXACT, 16'h0101, 0, 0));
		send_op(make_op(tte_pkg::OP_RECORD, 1'b1, 32'h0000_0101, 64'h1, 9, 255, -32767,
			tte_pkg::FLAG_EXACT, 16'h0102, 0, 0));
		send_op(make_op(tte_pkg::OP_RECORD, 1'b1, 32'h0000_0102, 64'h1, 9, 255, -32768,
			tte_pkg::FLAG_EXACT, 16'h0103, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b1, 32'h0000_0100, 64'h1, 9, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b1, 32'h0000_0101, 64'h1, 9, 7, 0,
			tte_pkg::FLAG_NONE, 16'h0, 0, 0));
		wait_drained();
		write_reg(ADDR_MATE, 15'h7FFF);
		write_reg(ADDR_WIN, 15'd0);
		send_op(make_op(tte_pkg::OP_RECORD, 1'b1, 32'h0000_0103, 64'h2, 1, 0, 0,
			tte_pkg::FLAG_LOWER, 16'h0104, 0, 0));
		send_op(make_op(tte_pkg::OP_RECORD, 1'b1, 32'h0000_0104, 64'h2, 1, 0, 1,
			tte_pkg::FLAG_LOWER, 16'h0105, 0, 0));
		send_op(make_op(tte_pkg::OP_PROBE, 1'b1, 32'h0000_0103, 64'h2, 1, 0, 0,
			tte_pkg::FLAG_NONE, 16'h0, 0, -1));
		wait_drained();
	endtask

	task automatic test_output_holdoff();
		gap_pct = 0;
		stall_pct = 0;
		hold_tog = !hold_tog;
		repeat (40) send_op(random_op());
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int gaps[4];
		int stalls[4];
		gaps = '{0, 56, 0, 28};
		stalls = '{0, 0, 56, 28};
		for (int p = 0; p < 4; p++) begin
			if (p == 3) begin
				write_reg(ADDR_MATE, tte_pkg::MATE_RESET);
				write_reg(ADDR_WIN, tte_pkg::WIN_RESET);
			end else begin
				write_reg(ADDR_MATE, 15'($urandom_range(32767, 20000)));
				write_reg(ADDR_WIN, 15'($urandom_range(32767, 25000)));
			end
			gap_pct = gaps[p];
			stall_pct = stalls[p];
			for (int n = 0; n < 290; n++) begin
				if (p == 2 && n == 150)
					send_op(make_op(tte_pkg::OP_AGE, 1'b0, 32'h0, 64'h0, 0, 0, 0,
						tte_pkg::FLAG_NONE, 16'h0, 0, 0));
				send_op(random_op());
			end
			wait_drained();
		end
	endtask

	// receiver: long hold-off on request, otherwise random stalls
	always @(posedge clk) begin
		if (hold_tog != hold_seen_q) begin
			hold_seen_q <= hold_tog;
			hold_left <= HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		tt_res_t want;
		tt_res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tdata[2:0];
			got.value = m_axis_tdata[18:3];
			got.hint = m_axis_tdata[34:19];
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, m_axis_tdata);
				errors++;
			end else begin
				want = pending_res.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						got.status);
					errors++;
				end
				if (got.value !== want.value) begin
					$display("%0t: value expected %0d actual %0d", $time,
						$signed(want.value), $signed(got.value));
					errors++;
				end
				if (got.hint !== want.hint) begin
					$display("%0t: hint_move expected %h actual %h", $time, want.hint,
						got.hint);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gap_pct = 0;
		stall_pct = 0;
		mate_lim = int'(tte_pkg::MATE_RESET);
		win_lim = int'(tte_pkg::WIN_RESET);
		idx_pool[0] = 16'h0000;
		idx_pool[1] = 16'hFFFF;
		for (int i = 2; i < 16; i++) idx_pool[i] = 16'($urandom);
		foreach (lock_pool[i]) lock_pool[i] = {$urandom, $urandom};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_clears();
		test_thresholds();
		test_output_holdoff();
		test_random_traffic();
		wait_drained();
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
